// File: rtl/core/dcf_pkg.sv
// Shared types and constants for the decimal command framer.
package dcf_pkg;

    // Decimal digit cells in the conversion row (enough for any 32-bit value)
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned POS_W      = 4;

    // ASCII framing characters
    localparam logic [7:0] CH_OPEN  = 8'h41;  // 'A'
    localparam logic [7:0] CH_CLOSE = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    // Input beat
    typedef struct packed {
        logic [7:0]  cmd_char;
        logic [31:0] value;
    } t_cmd;

    // Output beat
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } t_result;

    // Control from the sequencer to every digit cell
    typedef struct packed {
        logic clr;     // load zero
        logic dabble;  // add-3 correct and shift in one binary bit
        logic shift;   // take the lower neighbor's digit
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_OPEN,
        ST_LEN,
        ST_CMD,
        ST_DIGIT,
        ST_CLOSE
    } t_state;

endpackage

// File: rtl/core/decimal_command_framer.sv
// Top level: frames a command byte and a value as 'A', length, command, decimal digits, 'Z'.
//
// A command is taken when start is high and busy is low. The value's low
// VALUE_WIDTH bits are converted to decimal by a row of ten BCD digit cells,
// one binary bit per cycle. Leading zero digits are then shifted out of the
// row (at most nine), and a last check in the skip state finds the leading
// digit. The frame follows at one byte per cycle, 5 to 14 bytes, each shown
// for one cycle with o_strobe; the closing 'Z' carries last. The receiver
// cannot stall, so every byte must be taken when strobed. Busy stays high
// until the 'Z' byte has been launched.
module decimal_command_framer #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  dcf_pkg::t_cmd    i_cmd,
    output logic             busy,
    output logic             o_strobe,
    output dcf_pkg::t_result o_result
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

    dcf_pkg::t_state    r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [7:0]         r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [dcf_pkg::POS_W-1:0] r_pos, n_pos;
    logic               r_strobe, n_strobe;
    dcf_pkg::t_result   r_result, n_result;
    dcf_pkg::t_cell_ctl w_ctl;

    logic               w_bit   [dcf_pkg::MAX_DIGITS];
    logic [3:0]         w_digit [dcf_pkg::MAX_DIGITS];
    logic [3:0]         w_top;

    assign w_top = w_digit[dcf_pkg::MAX_DIGITS-1];

    // Digit cell row: binary bits ripple up through the add-3 carries,
    // whole digits move up one cell per cycle when shifting out
    assign w_bit[0] = r_val[VALUE_WIDTH-1];
    for (genvar k = 0; k < dcf_pkg::MAX_DIGITS; k++) begin : g_cell
        if (k == dcf_pkg::MAX_DIGITS - 1) begin : g_top
            dcf_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_bit[k]),
                .i_digit (w_digit[k-1]),
                .o_bit   (),
                .o_digit (w_digit[k])
            );
        end else if (k == 0) begin : g_low
            dcf_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_bit[k]),
                .i_digit (4'd0),
                .o_bit   (w_bit[k+1]),
                .o_digit (w_digit[k])
            );
        end else begin : g_mid
            dcf_bcd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_bit   (w_bit[k]),
                .i_digit (w_digit[k-1]),
                .o_bit   (w_bit[k+1]),
                .o_digit (w_digit[k])
            );
        end
    end

    // Sequencer: next state, cell control and next output beat
    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_cmd    = r_cmd;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_strobe = 1'b0;
        n_result = r_result;
        w_ctl    = '0;

        unique case (r_state)
            dcf_pkg::ST_IDLE: begin
                if (start) begin
                    n_val     = i_cmd.value[VALUE_WIDTH-1:0];
                    n_cmd     = i_cmd.cmd_char;
                    n_cnt     = CNT_W'(VALUE_WIDTH);
                    n_pos     = dcf_pkg::POS_W'(dcf_pkg::MAX_DIGITS);
                    w_ctl.clr = 1'b1;
                    n_state   = dcf_pkg::ST_CONV;
                end
            end
            dcf_pkg::ST_CONV: begin
                w_ctl.dabble = 1'b1;
                n_val        = r_val << 1;
                n_cnt        = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = dcf_pkg::ST_SKIP;
                end
            end
            dcf_pkg::ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_top == 4'd0 && r_pos > dcf_pkg::POS_W'(1)) begin
                    w_ctl.shift = 1'b1;
                    n_pos       = r_pos - dcf_pkg::POS_W'(1);
                end else begin
                    n_state = dcf_pkg::ST_OPEN;
                end
            end
            dcf_pkg::ST_OPEN: begin
                n_strobe = 1'b1;
                n_result = '{frame_byte: dcf_pkg::CH_OPEN, last: 1'b0};
                n_state  = dcf_pkg::ST_LEN;
            end
            dcf_pkg::ST_LEN: begin
                n_strobe = 1'b1;
                n_result = '{frame_byte: dcf_pkg::CH_ZERO + 8'd1 + 8'(r_pos), last: 1'b0};
                n_state  = dcf_pkg::ST_CMD;
            end
            dcf_pkg::ST_CMD: begin
                n_strobe = 1'b1;
                n_result = '{frame_byte: r_cmd, last: 1'b0};
                n_state  = dcf_pkg::ST_DIGIT;
            end
            dcf_pkg::ST_DIGIT: begin
                n_strobe    = 1'b1;
                n_result    = '{frame_byte: dcf_pkg::CH_ZERO + 8'(w_top), last: 1'b0};
                w_ctl.shift = 1'b1;
                n_pos       = r_pos - dcf_pkg::POS_W'(1);
                if (r_pos == dcf_pkg::POS_W'(1)) begin
                    n_state = dcf_pkg::ST_CLOSE;
                end
            end
            dcf_pkg::ST_CLOSE: begin
                n_strobe = 1'b1;
                n_result = '{frame_byte: dcf_pkg::CH_CLOSE, last: 1'b1};
                n_state  = dcf_pkg::ST_IDLE;
            end
            default: begin
                n_state = dcf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dcf_pkg::ST_IDLE;
            r_strobe <= 1'b0;
            r_pos    <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_cmd    <= n_cmd;
        r_result <= n_result;
    end

    assign busy     = (r_state != dcf_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A taken command always starts work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // The closing byte ends the frame: no beat follows it directly
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("beat directly after closing byte");

    // Digit position stays within the cell row while working, except in the closing state
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && r_state != dcf_pkg::ST_CLOSE |->
            r_pos >= dcf_pkg::POS_W'(1) &&
            r_pos <= dcf_pkg::POS_W'(dcf_pkg::MAX_DIGITS))
        else $error("digit position out of range");

    // Conversion counter never wraps during conversion
    a_cnt_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dcf_pkg::ST_CONV |-> r_cnt != '0)
        else $error("conversion counter underflow");

endmodule

// File: rtl/core/dcf_bcd_cell.sv
// One BCD digit cell of the binary-to-decimal shift row.
module dcf_bcd_cell (
    input  logic              i_clk,
    input  dcf_pkg::t_cell_ctl i_ctl,
    input  logic              i_bit,
    input  logic [3:0]        i_digit,
    output logic              o_bit,
    output logic [3:0]        o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add-3 correction before the shift; its top bit carries to the next cell
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        priority if (i_ctl.clr) begin
            n_digit = 4'd0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule
